FILE: rtl/cts_pkg.sv
// shared types, codes and helpers for the cyclic transmit scheduler
package cts_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int EMIT_W = 5;

    typedef enum logic [2:0] {
        CMD_ADD_CYCLIC = 3'd0,
        CMD_ADD_ONCE   = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_CLEAR      = 3'd3,
        CMD_SCAN       = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_FRAME   = 3'd0,
        KIND_DONE    = 3'd1,
        KIND_FULL    = 3'd2,
        KIND_MISSING = 3'd3,
        KIND_IDLE    = 3'd4
    } kind_t;

    // one table entry; flags bit 0 remote, bit 1 extended
    typedef struct packed {
        logic [28:0] id;
        logic [3:0]  len;
        logic [1:0]  flags;
        logic [63:0] data;
        logic [31:0] period;
        logic [31:0] due;
    } slot_t;

    // mask over the first len payload bytes, all eight above 8
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < len)
                m[b*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

endpackage

FILE: rtl/can_cyclic_tx_scheduler_core.sv
// top level of the cyclic CAN transmit scheduler core
//
// A command is taken when start is high and busy is low. Add and clear answer
// in the next cycle. Remove and scan walk the table through a memory with one
// write port and a registered read port, reading each stored entry in S_READ,
// processing it in S_PROC and closing in S_FINISH; busy falls in the cycle of
// the last result, and the walk compacts the table in place as entries are
// deleted. Each result is shown for exactly one cycle with result_valid high
// and cannot be stalled; last marks the final result of a command, and a scan
// emits at most 16 frames. Unknown commands give no result.
module can_cyclic_tx_scheduler_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] now_ms,
    input  logic [28:0] frame_id,
    input  logic [3:0]  frame_len,
    input  logic        remote_flag,
    input  logic        extended_flag,
    input  logic [63:0] payload,
    input  logic [31:0] period_ms,
    input  logic [31:0] first_due_ms,
    output logic        result_valid,
    output logic [2:0]  kind,
    output logic [28:0] out_id,
    output logic [3:0]  out_len,
    output logic        out_remote,
    output logic        out_extended,
    output logic [63:0] out_payload,
    output logic        last
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PROC,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        rd_idx_reg;
    logic [CW-1:0]        wr_idx_reg;
    logic [cts_pkg::EMIT_W-1:0] emit_reg;
    logic                 found_reg;
    logic                 is_scan_reg;
    logic [31:0]          now_reg;
    cts_pkg::slot_t       key_reg;
    cts_pkg::slot_t       buf_reg;

    logic                 result_valid_reg;
    logic [2:0]           kind_reg;
    logic [28:0]          out_id_reg;
    logic [3:0]           out_len_reg;
    logic                 out_remote_reg;
    logic                 out_extended_reg;
    logic [63:0]          out_payload_reg;
    logic                 last_reg;

    cts_pkg::slot_t       mem [TABLE_DEPTH];
    cts_pkg::slot_t       rd_data_reg;

    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    cts_pkg::slot_t       wr_data;
    cts_pkg::slot_t       new_slot;
    cts_pkg::slot_t       key_in;
    logic                 is_add;
    logic                 accept;
    logic                 hit;
    logic                 due_hit;
    logic                 keep;

    cts_match u_match (
        .entry (rd_data_reg),
        .key   (key_reg),
        .hit   (hit)
    );

    // entry and key built from the incoming transaction
    always_comb
    begin
        accept = start && (state_reg == S_IDLE);
        is_add = (command == cts_pkg::CMD_ADD_CYCLIC) || (command == cts_pkg::CMD_ADD_ONCE);
        new_slot.id    = frame_id;
        new_slot.len   = frame_len;
        new_slot.flags = {extended_flag, remote_flag};
        new_slot.data  = payload;
        new_slot.due   = first_due_ms;
        if (command == cts_pkg::CMD_ADD_ONCE)
            new_slot.period = 32'd0;
        else
            new_slot.period = (period_ms == 32'd0) ? 32'd1 : period_ms;
        key_in = new_slot;
        key_in.period = (period_ms == 32'd0) ? 32'd1 : period_ms;
    end

    // per-entry decision during a walk
    always_comb
    begin
        due_hit = (rd_data_reg.due <= now_reg) &&
                  (emit_reg < cts_pkg::EMIT_W'(cts_pkg::MAX_RESULTS));
        if (is_scan_reg)
            keep = !due_hit || (rd_data_reg.period != 32'd0);
        else
            keep = !(hit && !found_reg);
    end

    // memory write port: add in idle, compacting write-back during a walk
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IW-1:0];
        wr_data = new_slot;
        if (accept && is_add && (count_reg < CW'(TABLE_DEPTH)))
            wr_en = 1'b1;
        else if (state_reg == S_PROC)
        begin
            wr_en   = keep;
            wr_addr = wr_idx_reg[IW-1:0];
            wr_data = rd_data_reg;
            if (is_scan_reg && due_hit)
                wr_data.due = now_reg + rd_data_reg.period;
        end
    end

    // table memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_idx_reg[IW-1:0]];
    end

    // command sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            rd_idx_reg       <= '0;
            wr_idx_reg       <= '0;
            emit_reg         <= '0;
            found_reg        <= 1'b0;
            is_scan_reg      <= 1'b0;
            now_reg          <= '0;
            key_reg          <= '0;
            buf_reg          <= '0;
            result_valid_reg <= 1'b0;
            kind_reg         <= cts_pkg::KIND_DONE;
            out_id_reg       <= '0;
            out_len_reg      <= '0;
            out_remote_reg   <= 1'b0;
            out_extended_reg <= 1'b0;
            out_payload_reg  <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            last_reg         <= 1'b0;
            kind_reg         <= cts_pkg::KIND_DONE;
            out_id_reg       <= '0;
            out_len_reg      <= '0;
            out_remote_reg   <= 1'b0;
            out_extended_reg <= 1'b0;
            out_payload_reg  <= '0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        now_reg     <= now_ms;
                        key_reg     <= key_in;
                        rd_idx_reg  <= '0;
                        wr_idx_reg  <= '0;
                        emit_reg    <= '0;
                        found_reg   <= 1'b0;
                        is_scan_reg <= (command == cts_pkg::CMD_SCAN);
                        case (command) inside
                            cts_pkg::CMD_ADD_CYCLIC, cts_pkg::CMD_ADD_ONCE:
                            begin
                                result_valid_reg <= 1'b1;
                                last_reg         <= 1'b1;
                                if (count_reg < CW'(TABLE_DEPTH))
                                begin
                                    count_reg <= count_reg + 1'b1;
                                    kind_reg  <= cts_pkg::KIND_DONE;
                                end
                                else
                                    kind_reg <= cts_pkg::KIND_FULL;
                            end
                            cts_pkg::CMD_CLEAR:
                            begin
                                count_reg        <= '0;
                                result_valid_reg <= 1'b1;
                                last_reg         <= 1'b1;
                                kind_reg         <= cts_pkg::KIND_DONE;
                            end
                            cts_pkg::CMD_REMOVE, cts_pkg::CMD_SCAN:
                            begin
                                if (count_reg == '0)
                                    state_reg <= S_FINISH;
                                else
                                    state_reg <= S_READ;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_PROC;
                end
                S_PROC:
                begin
                    if (keep)
                        wr_idx_reg <= wr_idx_reg + 1'b1;
                    if (!is_scan_reg && hit && !found_reg)
                        found_reg <= 1'b1;
                    // flush the previous due frame, hold this one for last
                    if (is_scan_reg && due_hit)
                    begin
                        buf_reg  <= rd_data_reg;
                        emit_reg <= emit_reg + 1'b1;
                        if (emit_reg != '0)
                        begin
                            result_valid_reg <= 1'b1;
                            kind_reg         <= cts_pkg::KIND_FRAME;
                            out_id_reg       <= buf_reg.id;
                            out_len_reg      <= buf_reg.len;
                            out_remote_reg   <= buf_reg.flags[0];
                            out_extended_reg <= buf_reg.flags[1];
                            out_payload_reg  <= buf_reg.data;
                        end
                    end
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    if (rd_idx_reg + 1'b1 == count_reg)
                        state_reg <= S_FINISH;
                    else
                        state_reg <= S_READ;
                end
                S_FINISH:
                begin
                    count_reg        <= wr_idx_reg;
                    result_valid_reg <= 1'b1;
                    last_reg         <= 1'b1;
                    state_reg        <= S_IDLE;
                    if (!is_scan_reg)
                        kind_reg <= found_reg ? cts_pkg::KIND_DONE : cts_pkg::KIND_MISSING;
                    else if (emit_reg == '0)
                        kind_reg <= cts_pkg::KIND_IDLE;
                    else
                    begin
                        kind_reg         <= cts_pkg::KIND_FRAME;
                        out_id_reg       <= buf_reg.id;
                        out_len_reg      <= buf_reg.len;
                        out_remote_reg   <= buf_reg.flags[0];
                        out_extended_reg <= buf_reg.flags[1];
                        out_payload_reg  <= buf_reg.data;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign out_id       = out_id_reg;
    assign out_len      = out_len_reg;
    assign out_remote   = out_remote_reg;
    assign out_extended = out_extended_reg;
    assign out_payload  = out_payload_reg;
    assign last         = last_reg;

    // table fill never exceeds its depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(TABLE_DEPTH))
        else $error("table count above depth");

    // non-frame results always close their transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (kind != cts_pkg::KIND_FRAME)) |-> last)
        else $error("status result without last");

    // clear answers in the next cycle and empties the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == cts_pkg::CMD_CLEAR)) |=>
        (result_valid && (kind == cts_pkg::KIND_DONE) && (count_reg == '0)))
        else $error("clear did not complete");

    // compaction write pointer never passes the read pointer
    assert property (@(posedge clk) disable iff (!rst_n) wr_idx_reg <= rd_idx_reg)
        else $error("write pointer ahead of read pointer");

endmodule

FILE: rtl/cts_match.sv
// content compare of one table entry against the remove key
module cts_match (
    input  cts_pkg::slot_t entry,
    input  cts_pkg::slot_t key,
    output logic           hit
);

    logic [63:0] mask;

    // id, length, flags, interval and the valid payload bytes must agree
    always_comb
    begin
        mask = cts_pkg::byte_mask(key.len);
        hit  = (entry.id == key.id) && (entry.len == key.len) &&
               (entry.flags == key.flags) && (entry.period == key.period) &&
               (((entry.data ^ key.data) & mask) == 64'd0);
    end

endmodule
